// ----- rtl/assert_macros.svh -----
// Assertion macros of the fold block; the queue module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// A property that must hold at every clock edge outside reset.
`define MFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("Property does not hold.");
// A condition that must never be seen outside reset.
`define MFP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("Forbidden condition seen.");
`endif

// ----- rtl/mfp_pkg.sv -----
// Types and constants shared by the multilinear fold modules.
package mfp_pkg;
    localparam int LIMB_W = 64;
    localparam int ELEM_W = 256;
    localparam int CFG_IDX_W = 8;

    typedef logic [ELEM_W-1:0] t_elem;

    localparam t_elem P_MOD =
        256'h30644e72e131a029b85045b68181585d2833e84879b9709143e1f593f0000001;
    localparam logic [LIMB_W-1:0] N_INV = 64'hc2e1f593efffffff;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAL_LIMB0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAL_LIMB1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAL_LIMB2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAL_LIMB3 = 8'd3;

    typedef struct packed {
        logic [LIMB_W-1:0] low_limb0;
        logic [LIMB_W-1:0] low_limb1;
        logic [LIMB_W-1:0] low_limb2;
        logic [LIMB_W-1:0] low_limb3;
        logic [LIMB_W-1:0] high_limb0;
        logic [LIMB_W-1:0] high_limb1;
        logic [LIMB_W-1:0] high_limb2;
        logic [LIMB_W-1:0] high_limb3;
        logic              last_pair;
    } t_in_item;

    typedef struct packed {
        logic [LIMB_W-1:0] folded_limb0;
        logic [LIMB_W-1:0] folded_limb1;
        logic [LIMB_W-1:0] folded_limb2;
        logic [LIMB_W-1:0] folded_limb3;
        logic              last_result;
    } t_out_item;

    typedef struct packed {
        t_elem lo;
        t_elem diff;
        logic  last;
    } t_work;

    typedef struct packed {
        t_elem lo;
        logic  last;
    } t_side;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;
endpackage

// ----- rtl/mfp_front.sv -----
// Front end: accepts pairs and forms the reduced difference hi - lo.
module mfp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mfp_pkg::t_in_item i_in_item,
    input  logic             i_q_full,
    output logic             o_push,
    output mfp_pkg::t_work   o_work
);
    import mfp_pkg::*;

    logic        r_valid;
    t_elem       r_lo;
    t_elem       r_d;
    logic        r_br;
    logic        r_last;
    t_elem       n_lo;
    t_elem       n_hi;
    logic [ELEM_W:0] n_sub;

    assign n_lo = {i_in_item.low_limb3, i_in_item.low_limb2,
                   i_in_item.low_limb1, i_in_item.low_limb0};
    assign n_hi = {i_in_item.high_limb3, i_in_item.high_limb2,
                   i_in_item.high_limb1, i_in_item.high_limb0};
    assign n_sub = {1'b0, n_hi} - {1'b0, n_lo};

    assign o_in_ready = !r_valid || !i_q_full;
    assign o_push     = r_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_lo   <= n_lo;
            r_d    <= n_sub[ELEM_W-1:0];
            r_br   <= n_sub[ELEM_W];
            r_last <= i_in_item.last_pair;
        end
    end

    assign o_work.lo   = r_lo;
    assign o_work.diff = r_d + (r_br ? P_MOD : '0);
    assign o_work.last = r_last;
endmodule

// ----- rtl/mfp_queue.sv -----
// Short queue between the front end and the multiply pipeline.
`include "assert_macros.svh"
module mfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mfp_pkg::t_work     i_work,
    input  logic               i_pop,
    output mfp_pkg::t_work     o_work,
    output mfp_pkg::t_q_status o_status
);
    import mfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_work         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `MFP_ASSERT_NEVER(a_q_push_full, i_clk, i_rst_n, i_push && o_status.full)
    `MFP_ASSERT_NEVER(a_q_pop_empty, i_clk, i_rst_n, i_pop && o_status.empty)
    `MFP_ASSERT(a_q_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + CNT_W'(1))
    `MFP_ASSERT(a_q_empty_ptr, i_clk, i_rst_n, (r_cnt == '0) |-> (r_wr == r_rd))
endmodule

// ----- rtl/mfp_mont_round.sv -----
// One pipelined CIOS round: t = (t + a*b + m*p) / 2^64 over six stages.
module mfp_mont_round (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  logic [mfp_pkg::LIMB_W-1:0] i_a,
    input  mfp_pkg::t_elem           i_b,
    input  mfp_pkg::t_elem           i_t,
    input  mfp_pkg::t_side           i_side,
    output logic                     o_valid,
    output mfp_pkg::t_elem           o_b,
    output mfp_pkg::t_elem           o_t,
    output mfp_pkg::t_side           o_side
);
    import mfp_pkg::*;

    localparam int NSTG = 6;
    localparam int ACC_W = ELEM_W + LIMB_W;

    // Adds 64-bit-by-256-bit partial products of 32-bit halves to an accumulator.
    function automatic logic [ACC_W-1:0] pp_sum(input logic [1:0][7:0][63:0] pp,
                                                input logic [ACC_W-1:0] acc);
        logic [ELEM_W-1:0] a0, a1, b0, b1;
        for (int j = 0; j < 4; j++) begin
            a0[64*j +: 64] = pp[0][2*j];
            a1[64*j +: 64] = pp[0][2*j+1];
            b0[64*j +: 64] = pp[1][2*j];
            b1[64*j +: 64] = pp[1][2*j+1];
        end
        return acc + {64'b0, a0} + {32'b0, a1, 32'b0} + {32'b0, b0, 32'b0}
                   + {b1, 64'b0};
    endfunction

    logic [NSTG-1:0]        r_v;
    t_elem                  r_b [NSTG];
    t_side                  r_side [NSTG];
    logic [1:0][7:0][63:0]  r1_pp;
    t_elem                  r1_t;
    logic [ACC_W-1:0]       r2_u;
    logic [ACC_W-1:0]       r3_u;
    logic [ACC_W-1:0]       r4_u;
    logic [ACC_W-1:0]       r5_u;
    logic [63:0]            r3_m0;
    logic [31:0]            r3_m1;
    logic [31:0]            r3_m2;
    logic [LIMB_W-1:0]      r4_m;
    logic [1:0][7:0][63:0]  r5_q;
    t_elem                  r6_t;
    logic [63:0]            n_m1;
    logic [63:0]            n_m2;
    logic [ACC_W-1:0]       n_v;

    assign n_m1 = 64'(r2_u[31:0]) * 64'(N_INV[63:32]);
    assign n_m2 = 64'(r2_u[63:32]) * 64'(N_INV[31:0]);
    assign n_v  = pp_sum(r5_q, r5_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b[0]    <= i_b;
            r_side[0] <= i_side;
            for (int s = 1; s < NSTG; s++) begin
                r_b[s]    <= r_b[s-1];
                r_side[s] <= r_side[s-1];
            end
            for (int k = 0; k < 2; k++) begin
                for (int l = 0; l < 8; l++) begin
                    r1_pp[k][l] <= 64'(i_a[32*k +: 32]) * 64'(i_b[32*l +: 32]);
                    r5_q[k][l]  <= 64'(r4_m[32*k +: 32]) * 64'(P_MOD[32*l +: 32]);
                end
            end
            r1_t  <= i_t;
            r2_u  <= pp_sum(r1_pp, {64'b0, r1_t});
            r3_u  <= r2_u;
            r3_m0 <= 64'(r2_u[31:0]) * 64'(N_INV[31:0]);
            r3_m1 <= n_m1[31:0];
            r3_m2 <= n_m2[31:0];
            r4_u  <= r3_u;
            r4_m  <= r3_m0 + {r3_m1 + r3_m2, 32'b0};
            r5_u  <= r4_u;
            r6_t  <= n_v[ACC_W-1:LIMB_W];
        end
    end

    assign o_valid = r_v[NSTG-1];
    assign o_b     = r_b[NSTG-1];
    assign o_side  = r_side[NSTG-1];
    assign o_t     = r6_t;
endmodule

// ----- rtl/mfp_back.sv -----
// Back end: Montgomery multiply by the challenge, modular add and output register.
module mfp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mfp_pkg::t_elem     i_chal,
    input  logic               i_valid,
    output logic               o_pop,
    input  mfp_pkg::t_work     i_work,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mfp_pkg::t_out_item o_out_item
);
    import mfp_pkg::*;

    localparam int NRND = 4;

    logic            adv;
    logic            rv [NRND+1];
    t_elem           rb [NRND+1];
    t_elem           rt [NRND+1];
    t_side           rs [NRND+1];
    logic            r_f_valid;
    t_elem           r_prod;
    t_side           r_f_side;
    logic            r_s_valid;
    logic [ELEM_W:0] r_s;
    logic            r_s_last;
    logic            r_o_valid;
    t_elem           r_res;
    logic            r_last;
    logic [ELEM_W:0] n_fd;
    logic [ELEM_W:0] n_sd;

    assign adv   = !r_o_valid || i_out_ready;
    assign o_pop = adv && i_valid;

    assign rv[0]      = i_valid;
    assign rb[0]      = i_work.diff;
    assign rt[0]      = '0;
    assign rs[0].lo   = i_work.lo;
    assign rs[0].last = i_work.last;

    for (genvar g = 0; g < NRND; g++) begin : g_rnd
        mfp_mont_round u_rnd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (rv[g]),
            .i_a     (i_chal[LIMB_W*g +: LIMB_W]),
            .i_b     (rb[g]),
            .i_t     (rt[g]),
            .i_side  (rs[g]),
            .o_valid (rv[g+1]),
            .o_b     (rb[g+1]),
            .o_t     (rt[g+1]),
            .o_side  (rs[g+1])
        );
    end

    assign n_fd = {1'b0, rt[NRND]} - {1'b0, P_MOD};
    assign n_sd = {1'b0, r_s[ELEM_W-1:0]} - {1'b0, P_MOD};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_f_valid <= rv[NRND];
            r_s_valid <= r_f_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod   <= n_fd[ELEM_W] ? rt[NRND] : n_fd[ELEM_W-1:0];
            r_f_side <= rs[NRND];
            r_s      <= {1'b0, r_f_side.lo} + {1'b0, r_prod};
            r_s_last <= r_f_side.last;
            r_res    <= (r_s[ELEM_W] || !n_sd[ELEM_W]) ? n_sd[ELEM_W-1:0]
                                                      : r_s[ELEM_W-1:0];
            r_last   <= r_s_last;
        end
    end

    assign o_out_valid             = r_o_valid;
    assign o_out_item.folded_limb0 = r_res[63:0];
    assign o_out_item.folded_limb1 = r_res[127:64];
    assign o_out_item.folded_limb2 = r_res[191:128];
    assign o_out_item.folded_limb3 = r_res[255:192];
    assign o_out_item.last_result  = r_last;
endmodule

// ----- rtl/multilinear_fold_mod_p.sv -----
// Top level of the multilinear fold block over the BN254 scalar field.
// Each input transfer brings a pair (lo, hi) of Montgomery-form elements and a
// last flag; each output transfer returns lo + r*(hi - lo) mod p with the flag.
// The challenge r is written through the configuration channel, one 64-bit limb
// per transfer at indexes 0 to 3; other indexes are ignored. The configuration
// channel is always ready and should only be written while the block is idle.
// Both item channels use valid and ready. One pair is taken every cycle while
// the output side keeps up. With the queue empty, a result passes through one
// front stage, one queue entry, four six-stage Montgomery rounds, a final
// subtraction stage, an add stage and the output register. The four rounds
// each hold thirty-five 32-by-32 multipliers.
// When the receiver stalls, the back pipeline holds, the queue fills and the
// input ready falls once the queue and front stage are full.
// Reset clears the challenge to zero and empties the pipeline and the queue.
module multilinear_fold_mod_p #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mfp_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mfp_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mfp_pkg::LIMB_W-1:0]      i_cfg_data
);
    import mfp_pkg::*;

    logic [LIMB_W-1:0] r_chal [4];
    logic              push;
    logic              pop;
    t_work             f_work;
    t_work             q_work;
    t_q_status         q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_chal[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHAL_LIMB0: r_chal[0] <= i_cfg_data;
                CFG_CHAL_LIMB1: r_chal[1] <= i_cfg_data;
                CFG_CHAL_LIMB2: r_chal[2] <= i_cfg_data;
                CFG_CHAL_LIMB3: r_chal[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_status.full),
        .o_push     (push),
        .o_work     (f_work)
    );

    mfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (f_work),
        .i_pop    (pop),
        .o_work   (q_work),
        .o_status (q_status)
    );

    mfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_chal      ({r_chal[3], r_chal[2], r_chal[1], r_chal[0]}),
        .i_valid     (!q_status.empty),
        .o_pop       (pop),
        .i_work      (q_work),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );
endmodule
